[hdl/escape_pixel_stream_parser_assert.svh]
`ifndef ESCAPE_PIXEL_STREAM_PARSER_ASSERT_SVH
`define ESCAPE_PIXEL_STREAM_PARSER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
// The module that uses it must have clk and rst_n.
`define EPSP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define EPSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hdl/epsp_pkg.sv]
`timescale 1ns / 1ps

package epsp_pkg;

  // Characters of the command stream.
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_BRK  = 8'h5B;
  localparam logic [7:0] CH_X    = 8'h58;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_S    = 8'h73;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Result field widths.
  localparam int ADDR_BITS  = 32;
  localparam int COLOR_BITS = 24;
  localparam int DIM_BITS   = 16;

  // Entries in the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    KIND_PIXEL  = 1'b0,
    KIND_RESIZE = 1'b1
  } kind_t;

endpackage

[hdl/epsp_ifs.sv]
`timescale 1ns / 1ps

// Byte input channel.
interface epsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

// Result channel.
interface epsp_out_if import epsp_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [ADDR_BITS-1:0]  pixel_address;
  logic [COLOR_BITS-1:0] pixel_color;
  logic [DIM_BITS-1:0]   new_width;
  logic [DIM_BITS-1:0]   new_height;

  modport source (output valid, output kind, output pixel_address, output pixel_color,
                  output new_width, output new_height, input ready);
  modport sink (input valid, input kind, input pixel_address, input pixel_color,
                input new_width, input new_height, output ready);
endinterface

// Internal command channel between front, queue and back.
interface epsp_cmd_if #(parameter int DATA_BITS = 8);
  logic                 valid;
  logic                 ready;
  logic [DATA_BITS-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/epsp_front.sv]
`timescale 1ns / 1ps

module epsp_front import epsp_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  epsp_in_if.sink       in_bus,
  epsp_cmd_if.source    cmd
);

  localparam int WIDE = COORD_BITS + 4;

  typedef enum logic [3:0] {
    S_ESC, S_BRK, S_XTAG, S_XNUM, S_YNUM, S_B1, S_B2, S_B3, S_B4, S_NEXT
  } state_t;

  state_t                state_r, state_nxt;
  logic [COORD_BITS-1:0] x_r, x_nxt;
  logic [COORD_BITS-1:0] y_r, y_nxt;
  logic [COLOR_BITS-1:0] color_r, color_nxt;
  logic                  accept;
  logic                  is_digit;
  logic                  do_clear;
  logic [7:0]            ch;
  kind_t                 emit_kind;

  // Shift-and-add times ten, plus the digit, saturating at all ones.
  function automatic logic [COORD_BITS-1:0] dec_push(input logic [COORD_BITS-1:0] v,
                                                     input logic [7:0] c);
    logic [WIDE-1:0] wide;
    wide = (WIDE'(v) << 3) + (WIDE'(v) << 1) + WIDE'(c - CH_ZERO);
    return (wide[WIDE-1:COORD_BITS] != '0) ? '1 : wide[COORD_BITS-1:0];
  endfunction

  assign ch       = in_bus.byte_in;
  assign accept   = in_bus.valid && in_bus.ready;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

  // A byte is only taken when the queue has room for whatever it may emit.
  assign in_bus.ready = cmd.ready;
  assign emit_kind    = (state_r == S_B4) ? KIND_PIXEL : KIND_RESIZE;
  assign cmd.valid    = in_bus.valid &&
                        ((state_r == S_B4) || ((state_r == S_YNUM) && (ch == CH_S)));
  assign cmd.data     = {emit_kind, color_r, y_r, x_r};

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    color_nxt = color_r;
    do_clear  = 1'b0;
    if (accept) begin
      case (state_r)
        S_B1: begin
          color_nxt = color_r | COLOR_BITS'(ch);
          state_nxt = S_B2;
        end
        S_B2: begin
          color_nxt = color_r | (COLOR_BITS'(ch) << 8);
          state_nxt = S_B3;
        end
        S_B3: begin
          color_nxt = color_r | (COLOR_BITS'(ch) << 16);
          state_nxt = S_B4;
        end
        S_B4: begin
          state_nxt = S_NEXT;
        end
        S_NEXT: begin
          if (ch == CH_SEMI) begin
            color_nxt = '0;
            state_nxt = S_B1;
            if (x_r != '1) begin
              x_nxt = x_r + 1'b1;
            end
          end else begin
            do_clear = 1'b1;
          end
        end
        S_ESC: begin
          if (ch == CH_ESC) state_nxt = S_BRK;
          else do_clear = 1'b1;
        end
        S_BRK: begin
          if (ch == CH_BRK) state_nxt = S_XTAG;
          else do_clear = 1'b1;
        end
        S_XTAG: begin
          if (ch == CH_X) state_nxt = S_XNUM;
          else do_clear = 1'b1;
        end
        S_XNUM: begin
          if (is_digit) x_nxt = dec_push(x_r, ch);
          else if (ch == CH_SEMI) state_nxt = S_YNUM;
          else do_clear = 1'b1;
        end
        S_YNUM: begin
          if (is_digit) y_nxt = dec_push(y_r, ch);
          else if (ch == CH_SEMI) state_nxt = S_B1;
          else do_clear = 1'b1;
        end
        default: begin
          do_clear = 1'b1;
        end
      endcase
      // A resize command and any unexpected byte both leave the parser clean.
      if (do_clear) begin
        state_nxt = S_ESC;
        x_nxt     = '0;
        y_nxt     = '0;
        color_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ESC;
      x_r     <= '0;
      y_r     <= '0;
      color_r <= '0;
    end else begin
      state_r <= state_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      color_r <= color_nxt;
    end
  end

endmodule

[hdl/epsp_queue.sv]
`timescale 1ns / 1ps
`include "escape_pixel_stream_parser_assert.svh"

module epsp_queue import epsp_pkg::*; #(
  parameter int DATA_BITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  epsp_cmd_if.sink      up,
  epsp_cmd_if.source    down
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(QUEUE_DEPTH);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);

  logic [DATA_BITS-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]  count_r, count_nxt;
  logic                 push;
  logic                 pop;

  assign up.ready   = (count_r != FULL_CNT);
  assign down.valid = (count_r != '0);
  assign down.data  = mem_r[rd_ptr_r];
  assign push       = up.valid && up.ready;
  assign pop        = down.valid && down.ready;

  always_comb begin
    wr_ptr_nxt = push ? ((wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? ((rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= up.data;
    end
  end

  `EPSP_ASSERT_SAME(a_count_in_range, 1'b1, count_r <= FULL_CNT)
  `EPSP_ASSERT_NEXT(a_push_grows, push && !pop, count_r == $past(count_r) + 1'b1)
  `EPSP_ASSERT_NEXT(a_pop_shrinks, pop && !push, count_r == $past(count_r) - 1'b1)

endmodule

[hdl/epsp_back.sv]
`timescale 1ns / 1ps
`include "escape_pixel_stream_parser_assert.svh"

module epsp_back import epsp_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  epsp_cmd_if.sink      cmd,
  epsp_out_if.source    out_bus
);

  localparam int Y_LO     = COORD_BITS;
  localparam int COLOR_LO = 2 * COORD_BITS;
  localparam int KIND_POS = 2 * COORD_BITS + COLOR_BITS;

  logic [COORD_BITS-1:0] q_x;
  logic [COORD_BITS-1:0] q_y;
  logic [COLOR_BITS-1:0] q_color;
  kind_t                 q_kind;
  logic                  take;
  logic                  adv_out;

  logic [COORD_BITS-1:0] frame_width_r;

  // Multiply stage.
  logic                  m_v_r;
  kind_t                 m_kind_r;
  logic [ADDR_BITS-1:0]  m_prod_r;
  logic [ADDR_BITS-1:0]  m_x_r;
  logic [ADDR_BITS-1:0]  m_y_r;
  logic [COLOR_BITS-1:0] m_color_r;

  // Output register.
  logic                  out_v_r;
  kind_t                 out_kind_r;
  logic [ADDR_BITS-1:0]  out_addr_r;
  logic [COLOR_BITS-1:0] out_color_r;
  logic [DIM_BITS-1:0]   out_w_r;
  logic [DIM_BITS-1:0]   out_h_r;

  assign q_x     = cmd.data[COORD_BITS-1:0];
  assign q_y     = cmd.data[Y_LO +: COORD_BITS];
  assign q_color = cmd.data[COLOR_LO +: COLOR_BITS];
  assign q_kind  = kind_t'(cmd.data[KIND_POS]);

  assign adv_out   = !out_v_r || out_bus.ready;
  assign cmd.ready = !m_v_r || adv_out;
  assign take      = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= '0;
      m_v_r         <= 1'b0;
      out_v_r       <= 1'b0;
    end else begin
      // The width changes as the resize enters the multiply stage, so a pixel
      // right behind it already multiplies by the new width.
      if (take && (q_kind == KIND_RESIZE)) begin
        frame_width_r <= q_x;
      end
      if (cmd.ready) begin
        m_v_r <= cmd.valid;
      end
      if (adv_out) begin
        out_v_r <= m_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_kind_r  <= q_kind;
      m_prod_r  <= ADDR_BITS'(q_y) * ADDR_BITS'(frame_width_r);
      m_x_r     <= ADDR_BITS'(q_x);
      m_y_r     <= ADDR_BITS'(q_y);
      m_color_r <= q_color;
    end
    if (adv_out && m_v_r) begin
      out_kind_r <= m_kind_r;
      if (m_kind_r == KIND_RESIZE) begin
        out_addr_r  <= '0;
        out_color_r <= '0;
        out_w_r     <= m_x_r[DIM_BITS-1:0];
        out_h_r     <= m_y_r[DIM_BITS-1:0];
      end else begin
        out_addr_r  <= m_prod_r + m_x_r;
        out_color_r <= m_color_r;
        out_w_r     <= '0;
        out_h_r     <= '0;
      end
    end
  end

  assign out_bus.valid         = out_v_r;
  assign out_bus.kind          = out_kind_r;
  assign out_bus.pixel_address = out_addr_r;
  assign out_bus.pixel_color   = out_color_r;
  assign out_bus.new_width     = out_w_r;
  assign out_bus.new_height    = out_h_r;

  `EPSP_ASSERT_NEXT(a_resize_sets_width, take && (q_kind == KIND_RESIZE),
                    frame_width_r == $past(q_x))
  `EPSP_ASSERT_NEXT(a_mult_stage_holds, m_v_r && !adv_out, m_v_r)
  `EPSP_ASSERT_NEXT(a_mult_moves_out, m_v_r && adv_out, out_v_r)

endmodule

[hdl/escape_pixel_stream_parser.sv]
// Path: the command that a byte completes is written into the queue as its beat is taken,
// then passes the multiply stage and the output register on its way to out_bus.
// Throughput: one byte per cycle while the queue has room; at most one result per five bytes.
// The front takes a byte whenever the two-entry command queue has room.
// Reset: rst_n is synchronous and active low; it clears the parser, the queue, both
// back-end stages and the stored frame width. There is no clearing pass.
`timescale 1ns / 1ps

// The design splits into three parts.
//
// The front is the byte parser. It follows the escape sequence, accumulates
// the decimal coordinates with saturation, gathers the three color bytes and
// moves x forward after each pixel separator. Every byte is consumed in the
// cycle in which its beat is taken. When a byte completes a pixel or a resize
// command, the front pushes one command (kind, color, y, x) into the queue in
// that same cycle.
//
// The queue is a short FIFO that decouples the parser from the back end, so a
// stalled result consumer only backs up the byte stream once the queue fills.
//
// The back end owns the frame width. A resize updates it as the command leaves
// the queue; a pixel multiplies y by the current width in the first stage and
// adds x in the second, which is also the output register. The address wraps
// modulo 2^32. Fields that do not belong to the result kind are driven as zero.
module escape_pixel_stream_parser import epsp_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  epsp_in_if.sink       in_bus,
  epsp_out_if.source    out_bus
);

  // One command: kind, color, y, x from the top bit down.
  localparam int CMD_BITS = 2 * COORD_BITS + COLOR_BITS + 1;

  epsp_cmd_if #(.DATA_BITS(CMD_BITS)) front_cmd ();
  epsp_cmd_if #(.DATA_BITS(CMD_BITS)) back_cmd ();

  epsp_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .cmd    (front_cmd)
  );

  epsp_queue #(
    .DATA_BITS (CMD_BITS)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .up    (front_cmd),
    .down  (back_cmd)
  );

  epsp_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (back_cmd),
    .out_bus (out_bus)
  );

endmodule

[sim/escape_pixel_stream_parser_tb.sv]
`timescale 1ns / 1ps

// Testbench for the escape pixel stream parser.
//
// Bytes go in on in_bus, one per beat, and pixel writes and frame resizes come
// back on out_bus. The bench keeps its own model of the parser that runs on
// every input beat that the block takes, and a queue of the draw results that
// the model has produced but the block has not yet delivered. Each output beat
// is checked against the oldest entry of that queue, field by field.
//
// The byte stream is built before reset is released. A short directed opening
// covers pixels before any resize, the pixel step along x, extreme color bytes,
// an escape byte eaten by a parser that is not idle, and a resize with a
// saturated width. The random part is mostly well-formed commands with random
// content, mixed with truncated commands and loose noise bytes.
module escape_pixel_stream_parser_tb;
  import epsp_pkg::*;

  localparam int COORD_BITS = 16;
  localparam longint unsigned COORD_MAX = (64'd1 << COORD_BITS) - 1;
  localparam int DEC_BASE = 10;
  localparam int FEED_BYTES = 1900;
  localparam int MAX_WAIT = 14;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;

  // Where the parser is within a command.
  typedef enum logic [3:0] {
    PH_ESC, PH_BRACKET, PH_TAG, PH_XNUM, PH_YNUM,
    PH_COLOR_LO, PH_COLOR_MID, PH_COLOR_HI, PH_PAD, PH_SEP
  } parse_phase_t;

  typedef struct packed {
    kind_t                 kind;
    logic [ADDR_BITS-1:0]  pixel_address;
    logic [COLOR_BITS-1:0] pixel_color;
    logic [DIM_BITS-1:0]   new_width;
    logic [DIM_BITS-1:0]   new_height;
  } draw_result_t;

  // One byte waiting to be sent. When drain is set, the sender holds it back
  // until every draw result that is owed has been delivered.
  typedef struct {
    logic [7:0] value;
    bit         drain;
  } feed_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  epsp_in_if  in_bus ();
  epsp_out_if out_bus ();

  escape_pixel_stream_parser #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  feed_byte_t   byte_feed[$];
  draw_result_t draw_results_due[$];
  int           queued = 0;
  bit           pending_drain = 1'b0;

  // Parser model state.
  parse_phase_t          parse_phase;
  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS-1:0] row;
  logic [COLOR_BITS-1:0] color_acc;
  logic [COORD_BITS-1:0] frame_w;
  logic [COORD_BITS-1:0] frame_h;

  // Beats seen at the last rising edge, for the processes that act on the
  // falling edge.
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  int unsigned cycle_count = 0;
  int unsigned bytes_taken = 0;
  int unsigned fail_count = 0;

  // Flow control state of the two sides.
  int unsigned send_gap = 0;
  int unsigned recv_wait = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  logic        recv_hold = 1'b0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;

  // ---------------------------------------------------------------------------
  // Parser model.
  // ---------------------------------------------------------------------------

  // Decimal accumulation with saturation at the coordinate maximum.
  function automatic logic [COORD_BITS-1:0] coord_push(input logic [COORD_BITS-1:0] v,
                                                       input logic [7:0] ch);
    longint unsigned t;
    t = 64'(v) * DEC_BASE + 64'(ch - CH_ZERO);
    return (t > COORD_MAX) ? COORD_BITS'(COORD_MAX) : COORD_BITS'(t);
  endfunction

  // Advances the model by one accepted byte and queues the draw result that
  // it completes, if any.
  task automatic parse_stream_byte(input logic [7:0] ch);
    draw_result_t    res;
    logic            is_digit;
    logic            clear_all;
    longint unsigned full_addr;
    is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    clear_all = 1'b0;
    res       = '0;
    case (parse_phase)
      PH_COLOR_LO: begin
        color_acc[7:0] = ch;
        parse_phase    = PH_COLOR_MID;
      end
      PH_COLOR_MID: begin
        color_acc[15:8] = ch;
        parse_phase     = PH_COLOR_HI;
      end
      PH_COLOR_HI: begin
        color_acc[23:16] = ch;
        parse_phase      = PH_PAD;
      end
      PH_PAD: begin
        // The fourth byte of a pixel carries nothing; it only fires the write.
        full_addr         = 64'(col) + 64'(row) * 64'(frame_w);
        res.kind          = KIND_PIXEL;
        res.pixel_address = full_addr[ADDR_BITS-1:0];
        res.pixel_color   = color_acc;
        draw_results_due.push_back(res);
        parse_phase = PH_SEP;
      end
      PH_SEP: begin
        if (ch == CH_SEMI) begin
          color_acc   = '0;
          parse_phase = PH_COLOR_LO;
          if (64'(col) < COORD_MAX) col = col + 1'b1;
        end else begin
          clear_all = 1'b1;
        end
      end
      PH_ESC: begin
        if (ch == CH_ESC) parse_phase = PH_BRACKET;
        else clear_all = 1'b1;
      end
      PH_BRACKET: begin
        if (ch == CH_BRK) parse_phase = PH_TAG;
        else clear_all = 1'b1;
      end
      PH_TAG: begin
        if (ch == CH_X) parse_phase = PH_XNUM;
        else clear_all = 1'b1;
      end
      PH_XNUM: begin
        if (is_digit) col = coord_push(col, ch);
        else if (ch == CH_SEMI) parse_phase = PH_YNUM;
        else clear_all = 1'b1;
      end
      PH_YNUM: begin
        if (is_digit) begin
          row = coord_push(row, ch);
        end else if (ch == CH_SEMI) begin
          parse_phase = PH_COLOR_LO;
        end else if (ch == CH_S) begin
          frame_w        = col;
          frame_h        = row;
          res.kind       = KIND_RESIZE;
          res.new_width  = DIM_BITS'(frame_w);
          res.new_height = DIM_BITS'(frame_h);
          draw_results_due.push_back(res);
          clear_all = 1'b1;
        end else begin
          clear_all = 1'b1;
        end
      end
      default: clear_all = 1'b1;
    endcase
    if (clear_all) begin
      parse_phase = PH_ESC;
      col         = '0;
      row         = '0;
      color_acc   = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building.
  // ---------------------------------------------------------------------------

  task automatic put(input logic [7:0] value);
    feed_byte_t fb;
    fb.value = value;
    fb.drain = pending_drain;
    pending_drain = 1'b0;
    byte_feed.push_back(fb);
    queued++;
  endtask

  task automatic put_decimal(input int unsigned v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(CH_ZERO + 8'(v % DEC_BASE));
      v = v / DEC_BASE;
    end while (v != 0);
    foreach (digits[i]) put(digits[i]);
  endtask

  task automatic put_head();
    put(CH_ESC);
    put(CH_BRK);
    put(CH_X);
  endtask

  // A coordinate as the stream spells it. Mostly small values, so that
  // addresses stay readable, with some near the top, some long enough to
  // saturate, some with leading zeros and some left empty.
  task automatic put_coord();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      put_decimal($urandom_range(0, 300));
    end else if (pick < 80) begin
      put_decimal($urandom_range(65530, 65535));
    end else if (pick < 88) begin
      repeat ($urandom_range(6, 9)) put(CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (pick >= 94) begin
      repeat ($urandom_range(1, 4)) put(CH_ZERO);
      put_decimal($urandom_range(0, 99999));
    end
    // The remaining picks give no digits at all, which reads as zero.
  endtask

  // ---------------------------------------------------------------------------
  // Byte sender. It offers the head of byte_feed and drops it once the beat
  // has been taken; between bytes it idles for a drawn number of cycles.
  // ---------------------------------------------------------------------------

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  always @(negedge clk) begin : drive_bytes
    logic       offer;
    logic [7:0] data;
    offer = in_bus.valid;
    data  = in_bus.byte_in;
    if (!rst_n) begin
      offer = 1'b0;
    end else begin
      if (in_taken) begin
        void'(byte_feed.pop_front());
        offer = 1'b0;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        send_gap = draw_wait(send_calm);
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (byte_feed.size() > 0 &&
                     (!byte_feed[0].drain || draw_results_due.size() == 0)) begin
          offer = 1'b1;
          data  = byte_feed[0].value;
        end
      end
    end
    in_bus.valid   <= offer;
    in_bus.byte_in <= data;
  end

  // ---------------------------------------------------------------------------
  // Result receiver. After each beat it stalls for a drawn number of cycles,
  // and it also stays low while a long hold-off is running.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin : accept_results
    if (out_taken) begin
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      recv_wait = draw_wait(recv_calm);
    end
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= !recv_hold;
    end
  end

  // Two long hold-offs, started once enough bytes have gone in. The sender
  // keeps offering meanwhile, so the command queue fills and the block has to
  // stop taking bytes.
  always @(negedge clk) begin : hold_results
    if (hold_left > 0) begin
      hold_left--;
    end else if (holds_done < 2 && bytes_taken >= 400 + 900 * holds_done) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
    end
    recv_hold <= (hold_left != 0);
  end

  // ---------------------------------------------------------------------------
  // Monitor. Input beats feed the model before output beats are checked, so
  // the order holds whatever the latency.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input draw_result_t got,
                                 input draw_result_t want);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s at cycle %0d: got kind=%0d addr=%h color=%h w=%0d h=%0d",
               what, cycle_count, got.kind, got.pixel_address, got.pixel_color,
               got.new_width, got.new_height);
      $display("  expected kind=%0d addr=%h color=%h w=%0d h=%0d",
               want.kind, want.pixel_address, want.pixel_color,
               want.new_width, want.new_height);
    end
  endtask

  always @(posedge clk) begin : watch_beats
    draw_result_t got;
    draw_result_t want;
    cycle_count++;
    in_taken  <= rst_n && in_bus.valid && in_bus.ready;
    out_taken <= rst_n && out_bus.valid && out_bus.ready;
    if (!rst_n) begin
      parse_phase = PH_ESC;
      col         = '0;
      row         = '0;
      color_acc   = '0;
      frame_w     = '0;
      frame_h     = '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        parse_stream_byte(in_bus.byte_in);
        bytes_taken++;
      end
      if (out_bus.valid && out_bus.ready) begin
        got.kind          = kind_t'(out_bus.kind);
        got.pixel_address = out_bus.pixel_address;
        got.pixel_color   = out_bus.pixel_color;
        got.new_width     = out_bus.new_width;
        got.new_height    = out_bus.new_height;
        if (draw_results_due.size() == 0) begin
          report_mismatch("Result with none expected", got, '0);
        end else begin
          want = draw_results_due.pop_front();
          if (got.kind !== want.kind || got.pixel_address !== want.pixel_address ||
              got.pixel_color !== want.pixel_color || got.new_width !== want.new_width ||
              got.new_height !== want.new_height)
            report_mismatch("Result mismatch", got, want);
        end
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stream building, reset and the end of the run.
  // ---------------------------------------------------------------------------

  initial begin : run_stream
    int unsigned pick;
    int unsigned pixels;
    logic [7:0]  stray;
    bit          in_pixel_run;

    in_bus.valid   = 1'b0;
    in_bus.byte_in = '0;
    out_bus.ready  = 1'b0;

    // Pixels before any resize land at address x, and the second pixel of the
    // run steps one to the right. Color bytes reach both extremes.
    put_head();
    put(CH_ZERO + 8'd3);
    put(CH_SEMI);
    put(CH_ZERO + 8'd2);
    put(CH_SEMI);
    put(8'h00); put(8'hFF); put(8'h80); put(8'h11);
    put(CH_SEMI);
    put(8'hFF); put(8'h00); put(8'h7F); put(8'hEE);
    // An escape after a pixel is an unexpected byte: it only clears the parser.
    put(CH_ESC);
    // A resize whose width saturates.
    put_head();
    put_decimal(99999);
    put(CH_SEMI);
    put_decimal(1);
    put(CH_S);

    // The first random command waits until all directed results are in.
    pending_drain = 1'b1;
    in_pixel_run  = 1'b0;
    while (queued < FEED_BYTES) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 59) == 0) pending_drain = 1'b1;
      // After a pixel run the parser sits between pixels, so a fresh command
      // usually needs a stray byte first. Sometimes it is left out, and the
      // escape of the next command is swallowed.
      if (pick < 70 && in_pixel_run && $urandom_range(0, 4) != 0) begin
        stray = 8'($urandom_range(0, 255));
        if (stray == CH_SEMI) stray = CH_S;
        put(stray);
      end
      if (pick < 55) begin
        put_head();
        put_coord();
        put(CH_SEMI);
        put_coord();
        put(CH_SEMI);
        pixels = $urandom_range(1, 6);
        for (int k = 0; k < pixels; k++) begin
          if (k != 0) put(CH_SEMI);
          repeat (4) put(8'($urandom_range(0, 255)));
        end
        in_pixel_run = 1'b1;
      end else if (pick < 70) begin
        put_head();
        put_coord();
        put(CH_SEMI);
        put_coord();
        put(CH_S);
        in_pixel_run = 1'b0;
      end else if (pick < 85) begin
        // A command cut short at a random point, then a random byte.
        pixels = $urandom_range(0, 5);
        if (pixels > 0) put(CH_ESC);
        if (pixels > 1) put(CH_BRK);
        if (pixels > 2) put(CH_X);
        if (pixels > 3) put_coord();
        if (pixels > 4) put(CH_SEMI);
        put(8'($urandom_range(0, 255)));
        in_pixel_run = 1'b0;
      end else begin
        repeat ($urandom_range(1, 5)) put(8'($urandom_range(0, 255)));
        in_pixel_run = 1'b0;
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Every byte taken, every result delivered, then a few cycles in which a
    // stray result would still be caught.
    while (byte_feed.size() != 0) @(posedge clk);
    while (draw_results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && draw_results_due.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/epsp_pkg.sv
hdl/epsp_ifs.sv
hdl/epsp_front.sv
hdl/epsp_queue.sv
hdl/epsp_back.sv
hdl/escape_pixel_stream_parser.sv
sim/escape_pixel_stream_parser_tb.sv
